// ===== src/dqvs_pkg.sv =====
// ----------------------------------------------------------------------------
// dqvs_pkg
// Shared sizes, command and status codes, and cell control types for the
// deque with value search.
// ----------------------------------------------------------------------------
package dqvs_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IO_W        = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int IDX_W       = $clog2(CAPACITY);

	typedef enum logic [2:0] {
		CMD_ADD_FRONT = 3'd0,
		CMD_ADD_BACK  = 3'd1,
		CMD_REM_FRONT = 3'd2,
		CMD_REM_BACK  = 3'd3,
		CMD_CONTAINS  = 3'd4,
		CMD_REM_VALUE = 3'd5,
		CMD_PEEK      = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// broadcast to every cell for one transaction
	typedef struct packed {
		logic shift_right;     // take left neighbour (add at front)
		logic shift_left_all;  // take right neighbour (remove front)
		logic shift_on_hit;    // take right neighbour from the first hit on
		logic load_tail;       // cell at the tail takes the key
	} cell_ctrl_t;

	// where a cell stands relative to the fill level
	typedef struct packed {
		logic occupied;
		logic at_tail;
	} cell_pos_t;

endpackage

// ===== src/dqvs_cell.sv =====
// ----------------------------------------------------------------------------
// dqvs_cell
// One deque entry: holds a value, compares it with the key and passes the
// first-hit flag on to its right-hand neighbour.
// ----------------------------------------------------------------------------
module dqvs_cell (
	input  logic                              clk,
	input  dqvs_pkg::cell_ctrl_t              ctrl,
	input  dqvs_pkg::cell_pos_t               pos,
	input  logic [dqvs_pkg::VALUE_WIDTH-1:0]  key,
	input  logic [dqvs_pkg::VALUE_WIDTH-1:0]  left_value,
	input  logic [dqvs_pkg::VALUE_WIDTH-1:0]  right_value,
	input  logic                              hit_in,
	output logic                              hit_out,
	output logic [dqvs_pkg::VALUE_WIDTH-1:0]  value
);
	import dqvs_pkg::*;

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   match;

	assign match   = pos.occupied && (value_q == key);
	assign hit_out = hit_in || match;
	assign value   = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_right) begin
			value_q <= left_value;
		end else if (ctrl.shift_left_all || (ctrl.shift_on_hit && hit_out)) begin
			value_q <= right_value;
		end else if (ctrl.load_tail && pos.at_tail) begin
			value_q <= key;
		end
	end

endmodule

// ===== src/dqvs_chain.sv =====
// ----------------------------------------------------------------------------
// dqvs_chain
// Row of entry cells, front at cell zero. Carries the hit chain across the
// row and presents the front and back entries.
// ----------------------------------------------------------------------------
module dqvs_chain (
	input  logic                              clk,
	input  dqvs_pkg::cell_ctrl_t              ctrl,
	input  logic [dqvs_pkg::VALUE_WIDTH-1:0]  key,
	input  logic [dqvs_pkg::CNT_W-1:0]        count,
	output logic                              hit,
	output logic [dqvs_pkg::VALUE_WIDTH-1:0]  front,
	output logic [dqvs_pkg::VALUE_WIDTH-1:0]  back
);
	import dqvs_pkg::*;

	logic [VALUE_WIDTH-1:0] vals [CAPACITY];
	logic [CAPACITY:0]      hit_chain;
	logic [IDX_W-1:0]       back_idx;

	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_pos_t              pos;
		logic [VALUE_WIDTH-1:0] left_v;
		logic [VALUE_WIDTH-1:0] right_v;

		assign pos.occupied = CNT_W'(i) < count;
		assign pos.at_tail  = CNT_W'(i) == count;

		if (i == 0) begin : g_first
			assign left_v = key;
		end else begin : g_mid
			assign left_v = vals[i-1];
		end

		// the last cell never takes from the right while it is occupied
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = vals[i];
		end else begin : g_inner
			assign right_v = vals[i+1];
		end

		dqvs_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.pos         (pos),
			.key         (key),
			.left_value  (left_v),
			.right_value (right_v),
			.hit_in      (hit_chain[i]),
			.hit_out     (hit_chain[i+1]),
			.value       (vals[i])
		);
	end

	assign hit      = hit_chain[CAPACITY];
	assign back_idx = IDX_W'(count - CNT_W'(1));
	assign front    = vals[0];
	assign back     = vals[back_idx];

endmodule

// ===== src/deque_with_value_search_unit.sv =====
// After a command is accepted, fmt_q is registered and res_valid is then raised with the formed result.
// A new command is not taken while a result is being formed or while a held result is stalled.
// The key compare in every cell and the first-hit chain along the row
// settle in the cycle of acceptance; the result is formed in the next.
// Reset clears fill level and handshake state; entry cells are not cleared.
// ----------------------------------------------------------------------------
// deque_with_value_search_unit
// Bounded deque of signed values with contains and remove-by-value, built
// as a shifting row of cells. One result per command.
// ----------------------------------------------------------------------------
module deque_with_value_search_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         command,
	input  logic signed [31:0] item_value,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [1:0]         status,
	output logic               found,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value,
	output logic [4:0]         entry_count,
	output logic               is_empty
);
	import dqvs_pkg::*;

	logic                   accept;
	logic                   fmt_q;
	logic                   res_valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic [1:0]             status_q;
	logic                   found_q;
	status_t                st_d;
	logic                   found_d;
	cell_ctrl_t             ctrl_d;
	cell_ctrl_t             cell_ctrl;
	logic [VALUE_WIDTH-1:0] key;
	logic                   hit;
	logic [VALUE_WIDTH-1:0] front;
	logic [VALUE_WIDTH-1:0] back;
	logic                   full;
	logic                   empty;

	assign cmd_stall = fmt_q || (res_valid_q && res_stall);
	assign accept    = cmd_valid && !cmd_stall;
	assign key       = VALUE_WIDTH'(item_value);
	assign full      = count_q == CNT_W'(CAPACITY);
	assign empty     = count_q == '0;
	assign cell_ctrl = accept ? ctrl_d : '0;

	always_comb begin
		ctrl_d  = '0;
		st_d    = ST_OK;
		found_d = 1'b0;
		count_d = count_q;
		case (command)
			CMD_ADD_FRONT: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					ctrl_d.shift_right = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_ADD_BACK: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					ctrl_d.load_tail = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_REM_FRONT: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					ctrl_d.shift_left_all = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_REM_BACK: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_CONTAINS: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					found_d = hit;
				end
			end
			CMD_REM_VALUE: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else if (!hit) begin
					st_d = ST_NOT_FOUND;
				end else begin
					// cells from the first hit onward close the gap
					ctrl_d.shift_on_hit = 1'b1;
					found_d = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_PEEK: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	dqvs_chain u_chain (
		.clk   (clk),
		.ctrl  (cell_ctrl),
		.key   (key),
		.count (count_q),
		.hit   (hit),
		.front (front),
		.back  (back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fmt_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			fmt_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
			if (fmt_q) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st_d;
			found_q  <= found_d;
		end
		if (fmt_q) begin
			status      <= status_q;
			found       <= found_q;
			entry_count <= 5'(count_q);
			is_empty    <= count_q == '0;
			front_value <= (count_q == '0) ? '0 : $signed(IO_W'(front));
			back_value  <= (count_q == '0) ? '0 : $signed(IO_W'(back));
		end
	end

	assign res_valid = res_valid_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill level beyond capacity");

	a_fmt_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		fmt_q |-> !res_valid_q)
		else $error("result register busy when a result is formed");

	a_accept_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> fmt_q && cmd_stall)
		else $error("accepted command not followed by result formation");

	a_fmt_result: assert property (@(posedge clk) disable iff (!arst_n)
		fmt_q |=> res_valid && entry_count == 5'(count_q))
		else $error("result missing or count mismatch");
`endif

endmodule
